@@ src/magic_sync_frame_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef MAGIC_SYNC_FRAME_RECEIVER_DEFINES_SVH
`define MAGIC_SYNC_FRAME_RECEIVER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define MSFR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Antecedent in a cycle implies the consequent in the same cycle.
`define MSFR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/msfr_pkg.sv @@
// ----------------------------------------------------------------------------
// msfr_pkg
// Widths, register indexes and frame layout of the sync frame receiver.
// ----------------------------------------------------------------------------
package msfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 32;
  localparam int ID_W    = 32;
  localparam int MAGIC_W = 32;
  localparam int TYPE_W  = 8;
  localparam int LEN_W   = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_REQUEST_TYPE = CFG_IDX_W'(1);

  // Frame layout
  localparam int MAGIC_BYTES  = MAGIC_W / BYTE_W;
  localparam int HEADER_BYTES = 8;
  localparam int TYPE_POS     = 5;
  localparam int LEN_LO_POS   = 6;
  localparam int LEN_HI_POS   = 7;

  localparam int BUFFER_BYTES_DEF  = 128;
  localparam int REQUEST_BYTES_DEF = 4;

endpackage

@@ src/msfr_if.sv @@
// ----------------------------------------------------------------------------
// msfr interfaces
// Valid/ready channels for received bytes, sync results and register writes.
// ----------------------------------------------------------------------------
interface msfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [msfr_pkg::BYTE_W-1:0] rx_byte;
  logic [msfr_pkg::TIME_W-1:0] time_us;

  modport source (output valid, output rx_byte, output time_us, input ready);
  modport sink   (input valid, input rx_byte, input time_us, output ready);
endinterface

interface msfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [msfr_pkg::ID_W-1:0]   sync_id;
  logic [msfr_pkg::TIME_W-1:0] done_us;

  modport source (output valid, output sync_id, output done_us, input ready);
  modport sink   (input valid, input sync_id, input done_us, output ready);
endinterface

interface msfr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [msfr_pkg::CFG_IDX_W-1:0]  index;
  logic [msfr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/magic_sync_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// magic_sync_frame_receiver
// Hunts for a magic word in a byte stream, parses an 8-byte header and
// reports sync requests with their completion time.
// ----------------------------------------------------------------------------
// One received byte is taken per clock. A byte lands in an input register,
// and once the output register is free the frame parser updates its state
// from it and writes any sync result to the output register, so a result is
// registered from the byte that completes the frame. The only thing that
// slows input down is a result left waiting in the output register while
// out_ch.ready is low. Frames that grow to BUFFER_BYTES bytes are dropped
// and hunting restarts with the next byte. Register writes are always
// accepted.
`include "magic_sync_frame_receiver_defines.svh"

module magic_sync_frame_receiver #(
  parameter int BUFFER_BYTES  = msfr_pkg::BUFFER_BYTES_DEF,
  parameter int REQUEST_BYTES = msfr_pkg::REQUEST_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  msfr_in_if.sink   in_ch,
  msfr_out_if.source out_ch,
  msfr_cfg_if.sink  cfg_ch
);

  localparam int HELD_W = $clog2(BUFFER_BYTES + 1);
  localparam int CAP_W  = msfr_pkg::BYTE_W * REQUEST_BYTES;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  // Configuration
  logic [msfr_pkg::MAGIC_W-1:0] magic_r;
  logic [msfr_pkg::TYPE_W-1:0]  sync_type_r;

  // Input stage
  logic                        s1_valid_r;
  logic [msfr_pkg::BYTE_W-1:0] s1_byte_r;
  logic [msfr_pkg::TIME_W-1:0] s1_time_r;

  // Parser state
  phase_t                       phase_r, phase_nxt;
  logic [HELD_W-1:0]            held_r, held_nxt;
  logic [msfr_pkg::MAGIC_W-1:0] recent_r, recent_nxt;
  logic [msfr_pkg::TYPE_W-1:0]  type_r, type_nxt;
  logic [msfr_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [CAP_W-1:0]             cap_r, cap_nxt;

  // Result register
  logic                        out_valid_r;
  logic [msfr_pkg::ID_W-1:0]   out_id_r;
  logic [msfr_pkg::TIME_W-1:0] out_time_r;

  logic                         out_free;
  logic                         s1_fire;
  logic                         ovf;
  logic                         emit;
  logic [HELD_W-1:0]            hunt_cnt;
  logic [msfr_pkg::MAGIC_W-1:0] hunt_recent;
  logic [HELD_W-1:0]            pay_idx;
  logic [HELD_W-1:0]            pay_cnt_nxt;
  logic                         is_request;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.sync_id = out_id_r;
  assign out_ch.done_us = out_time_r;

  // A full buffer throws away the frame; the byte then starts a fresh hunt.
  assign ovf         = (phase_r != PH_HUNT) && (held_r >= HELD_W'(BUFFER_BYTES));
  assign hunt_cnt    = ovf ? '0 : held_r;
  assign hunt_recent = ovf ? '0 : recent_r;
  assign pay_idx     = held_r - HELD_W'(msfr_pkg::HEADER_BYTES);
  assign pay_cnt_nxt = pay_idx + HELD_W'(1);
  assign is_request  = (type_r == sync_type_r);

  always_comb begin
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    recent_nxt = recent_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    cap_nxt    = cap_r;
    emit       = 1'b0;
    if (ovf || phase_r == PH_HUNT) begin
      recent_nxt = {s1_byte_r, hunt_recent[msfr_pkg::MAGIC_W-1:msfr_pkg::BYTE_W]};
      held_nxt   = (hunt_cnt < HELD_W'(msfr_pkg::MAGIC_BYTES)) ?
                   HELD_W'(hunt_cnt + HELD_W'(1)) : hunt_cnt;
      phase_nxt  = PH_HUNT;
      if (held_nxt == HELD_W'(msfr_pkg::MAGIC_BYTES) && recent_nxt == magic_r) begin
        phase_nxt = PH_HEADER;
      end
    end else begin
      case (phase_r)
        PH_HEADER: begin
          held_nxt = HELD_W'(held_r + HELD_W'(1));
          if (held_r == HELD_W'(msfr_pkg::TYPE_POS)) begin
            type_nxt = s1_byte_r;
          end else if (held_r == HELD_W'(msfr_pkg::LEN_LO_POS)) begin
            len_nxt = msfr_pkg::LEN_W'(s1_byte_r);
          end else if (held_r == HELD_W'(msfr_pkg::LEN_HI_POS)) begin
            len_nxt = {s1_byte_r, len_r[msfr_pkg::BYTE_W-1:0]};
            cap_nxt = '0;
            if (len_nxt == '0) begin
              // empty payload: frame ends on the last header byte
              emit       = is_request && (len_nxt == msfr_pkg::LEN_W'(REQUEST_BYTES));
              phase_nxt  = PH_HUNT;
              held_nxt   = '0;
              recent_nxt = '0;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          for (int i = 0; i < REQUEST_BYTES; i++) begin
            if (pay_idx == HELD_W'(i)) begin
              cap_nxt[i*msfr_pkg::BYTE_W +: msfr_pkg::BYTE_W] = s1_byte_r;
            end
          end
          held_nxt = HELD_W'(held_r + HELD_W'(1));
          if (msfr_pkg::LEN_W'(pay_cnt_nxt) >= len_r) begin
            emit       = is_request && (len_r == msfr_pkg::LEN_W'(REQUEST_BYTES));
            phase_nxt  = PH_HUNT;
            held_nxt   = '0;
            recent_nxt = '0;
          end
        end
        default: begin
          phase_nxt  = PH_HUNT;
          held_nxt   = '0;
          recent_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r     <= '0;
      sync_type_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == msfr_pkg::REG_MAGIC_WORD) begin
        magic_r <= cfg_ch.data;
      end else if (cfg_ch.index == msfr_pkg::REG_SYNC_REQUEST_TYPE) begin
        sync_type_r <= cfg_ch.data[msfr_pkg::TYPE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_time_r <= in_ch.time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      held_r   <= '0;
      recent_r <= '0;
      type_r   <= '0;
      len_r    <= '0;
      cap_r    <= '0;
    end else if (s1_fire) begin
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      recent_r <= recent_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      cap_r    <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_id_r   <= msfr_pkg::ID_W'(cap_nxt);
      out_time_r <= s1_time_r;
    end
  end

  `MSFR_ASSERT_IMPLIES(a_hunt_count, phase_r == PH_HUNT,
      held_r <= HELD_W'(msfr_pkg::MAGIC_BYTES), "hunt byte count above magic size")
  `MSFR_ASSERT_ALWAYS(a_buffer_bound, held_r <= HELD_W'(BUFFER_BYTES),
      "held byte count beyond buffer size")
  `MSFR_ASSERT_IMPLIES(a_payload_past_header, phase_r == PH_PAYLOAD,
      held_r >= HELD_W'(msfr_pkg::HEADER_BYTES), "payload phase inside header")
  `MSFR_ASSERT_IMPLIES(a_stall_cause, !in_ch.ready,
      s1_valid_r && out_valid_r && !out_ch.ready, "input stalled without a held result")
  `MSFR_ASSERT_IMPLIES(a_result_source, out_valid_r && !$past(out_valid_r),
      $past(s1_fire), "result appeared without a parsed byte")

endmodule
